// ===== rtl/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, codes and defaults of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int HEAP_WORDS_DEF     = 512;
  localparam int SLOTS_PER_TASK_DEF = 8;
  localparam int TASKS_DEF          = 4;

  // occupancy bitmap is stored as rows of ROW_BITS words
  localparam int ROW_BITS  = 8;
  localparam int ROW_SEL_W = 3;

  localparam logic [2:0] OP_ALLOC     = 3'd0;
  localparam logic [2:0] OP_FREE      = 3'd1;
  localparam logic [2:0] OP_RESERVE   = 3'd2;
  localparam logic [2:0] OP_RELEASE   = 3'd3;
  localparam logic [2:0] OP_TRANSLATE = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SPACE   = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  task_req;
    logic [15:0] size;
    logic [8:0]  address;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] result_address;
  } out_item_t;

  typedef enum logic [1:0] {
    MS_SEG   = 2'd0,
    MS_ENTRY = 2'd1,
    MS_START = 2'd2
  } mark_src_t;

  typedef enum logic [1:0] {
    RS_ZERO  = 2'd0,
    RS_ADDR  = 2'd1,
    RS_START = 2'd2,
    RS_XLATE = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic       accept;
    logic       clr_wr;
    logic       row_zero;
    logic       row_inc;
    logic       scan_rd;
    logic       scan_step;
    logic       slot_zero;
    logic       slot_rd;
    logic       slot_inc;
    logic       slot_take;
    logic       mark_load;
    mark_src_t  mark_src;
    logic       mark_val;
    logic       mark_rd;
    logic       mark_wr;
    logic       seg_clear;
    logic       seg_set;
    logic       res_set;
    logic [2:0] res_code;
    res_sel_t   res_sel;
    logic       load_out;
  } bffa_cmd_t;

  typedef struct packed {
    logic bad_req;
    logic is_alloc;
    logic is_free;
    logic is_reserve;
    logic is_release;
    logic is_translate;
    logic size_bad;
    logic seg_valid;
    logic clear_last;
    logic scan_found;
    logic scan_last;
    logic slot_hit;
    logic slot_last;
    logic mark_last;
    logic out_busy;
  } bffa_sts_t;

endpackage

// ===== rtl/bffa_ram.sv =====
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bffa_datapath.sv =====
// ----------------------------------------------------------------------------
// bffa_datapath
// Bitmap and slot table storage, run search, range marking and result regs.
// ----------------------------------------------------------------------------
module bffa_datapath import bffa_pkg::*; #(
  parameter int HEAP_WORDS     = HEAP_WORDS_DEF,
  parameter int SLOTS_PER_TASK = SLOTS_PER_TASK_DEF,
  parameter int TASKS          = TASKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  bffa_cmd_t cmd,
  output bffa_sts_t sts
);

  localparam int HW      = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int LW      = $clog2(HEAP_WORDS + 1);
  localparam int ROWS    = (HEAP_WORDS + ROW_BITS - 1) / ROW_BITS;
  localparam int RAW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW      = RAW + ROW_SEL_W;
  localparam int ENTRIES = TASKS * SLOTS_PER_TASK;
  localparam int EAW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW      = (SLOTS_PER_TASK > 1) ? $clog2(SLOTS_PER_TASK) : 1;
  localparam int TW      = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int WW      = (HW > 10) ? HW : 10;
  localparam int XW      = ((HW > 9) ? HW : 9) + 1;

  in_item_t          req_r;
  logic [RAW-1:0]    row_r;
  logic [SW-1:0]     slot_r;
  logic [LW-1:0]     run_r;
  logic [HW-1:0]     first_r;
  logic [HW-1:0]     start_r;
  logic [HW-1:0]     mark_lo_r;
  logic [HW-1:0]     mark_hi_r;
  logic              mark_val_r;
  logic [ENTRIES-1:0] entry_valid_r;
  logic [TASKS-1:0]  seg_valid_r;
  logic [HW-1:0]     seg_base_r [TASKS];
  logic [LW-1:0]     seg_len_r [TASKS];
  logic [2:0]        res_status_r;
  logic [9:0]        res_addr_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [ROW_BITS-1:0] map_q;
  logic [ROW_BITS-1:0] marked;
  logic [HW+LW-1:0]    ent_q;
  logic [HW-1:0]       ent_start;
  logic [LW-1:0]       ent_len;
  logic [EAW-1:0]      eidx;
  logic [TW-1:0]       tidx;
  logic [LW-1:0]       size_len;
  logic                task_ok;

  logic [LW-1:0]       run_v;
  logic [HW-1:0]       first_v;
  logic                found_v;
  logic [HW-1:0]       fpos_v;

  logic [HW-1:0]       ld_lo;
  logic [LW-1:0]       ld_len;
  logic [LW:0]         ld_sum;
  logic [HW-1:0]       ld_hi;
  logic [PW-1:0]       ld_lo_p;
  logic [PW-1:0]       hi_p;

  logic                xl_hit;
  logic [XW-1:0]       xl_sum;
  logic [9:0]          xl_res;
  logic [WW-1:0]       start_w;

  assign eidx      = EAW'(req_r.task_req) * EAW'(SLOTS_PER_TASK) + EAW'(slot_r);
  assign tidx      = TW'(req_r.task_req);
  assign size_len  = LW'(req_r.size);
  assign task_ok   = 32'(req_r.task_req) < TASKS;
  assign ent_start = ent_q[HW+LW-1:LW];
  assign ent_len   = ent_q[LW-1:0];

  bffa_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map_ram (
    .clk   (clk),
    .we    (cmd.clr_wr | cmd.mark_wr),
    .waddr (row_r),
    .wdata (cmd.clr_wr ? '0 : marked),
    .re    (cmd.scan_rd | cmd.mark_rd),
    .raddr (row_r),
    .rdata (map_q)
  );

  bffa_ram #(.WIDTH(HW + LW), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (cmd.slot_take & sts.is_alloc),
    .waddr (eidx),
    .wdata ({start_r, size_len}),
    .re    (cmd.slot_rd),
    .raddr (eidx),
    .rdata (ent_q)
  );

  // first-fit run tracking across one bitmap row; words past the heap count as used
  always_comb begin
    logic [PW-1:0] p;
    run_v   = run_r;
    first_v = first_r;
    found_v = 1'b0;
    fpos_v  = first_r;
    for (int i = 0; i < ROW_BITS; i++) begin
      p = {row_r, ROW_SEL_W'(i)};
      if (!found_v) begin
        if (map_q[i] || (32'(p) >= HEAP_WORDS)) begin
          run_v = '0;
        end else begin
          if (run_v == '0) begin
            first_v = HW'(p);
          end
          run_v = run_v + 1'b1;
          if (run_v == size_len) begin
            found_v = 1'b1;
            fpos_v  = first_v;
          end
        end
      end
    end
  end

  always_comb begin
    logic [PW-1:0] p;
    for (int i = 0; i < ROW_BITS; i++) begin
      p = {row_r, ROW_SEL_W'(i)};
      marked[i] = ((p >= PW'(mark_lo_r)) && (p <= PW'(mark_hi_r))) ? mark_val_r : map_q[i];
    end
  end

  always_comb begin
    unique case (cmd.mark_src)
      MS_SEG: begin
        ld_lo  = seg_base_r[tidx];
        ld_len = seg_len_r[tidx];
      end
      MS_ENTRY: begin
        ld_lo  = ent_start;
        ld_len = ent_len;
      end
      default: begin
        ld_lo  = start_r;
        ld_len = size_len;
      end
    endcase
    ld_sum  = (LW+1)'(ld_lo) + (LW+1)'(ld_len) - 1'b1;
    ld_hi   = (32'(ld_sum) > HEAP_WORDS - 1) ? HW'(HEAP_WORDS - 1) : ld_sum[HW-1:0];
    ld_lo_p = PW'(ld_lo);
    hi_p    = PW'(mark_hi_r);
  end

  assign xl_hit  = seg_valid_r[tidx] && (32'(req_r.address) < 32'(seg_len_r[tidx]));
  assign xl_sum  = XW'(seg_base_r[tidx]) + XW'(req_r.address);
  assign xl_res  = xl_hit ? xl_sum[9:0] : 10'(req_r.address);
  assign start_w = WW'(start_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r         <= '0;
      slot_r        <= '0;
      entry_valid_r <= '0;
      seg_valid_r   <= '0;
      out_valid_r   <= 1'b0;
      for (int t = 0; t < TASKS; t++) begin
        seg_len_r[t] <= '0;
      end
    end else begin
      if (cmd.mark_load) begin
        row_r <= ld_lo_p[PW-1:ROW_SEL_W];
      end else if (cmd.row_zero) begin
        row_r <= '0;
      end else if (cmd.row_inc) begin
        row_r <= row_r + 1'b1;
      end

      if (cmd.slot_zero) begin
        slot_r <= '0;
      end else if (cmd.slot_inc) begin
        slot_r <= slot_r + 1'b1;
      end

      if (cmd.slot_take) begin
        entry_valid_r[eidx] <= sts.is_alloc;
      end

      if (cmd.seg_clear) begin
        seg_valid_r[tidx] <= 1'b0;
        seg_len_r[tidx]   <= '0;
      end else if (cmd.seg_set) begin
        seg_valid_r[tidx] <= 1'b1;
        seg_len_r[tidx]   <= size_len;
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
    if (cmd.row_zero) begin
      run_r <= '0;
    end else if (cmd.scan_step) begin
      run_r   <= run_v;
      first_r <= first_v;
      if (found_v) begin
        start_r <= fpos_v;
      end
    end
    if (cmd.mark_load) begin
      mark_lo_r  <= ld_lo;
      mark_hi_r  <= ld_hi;
      mark_val_r <= cmd.mark_val;
    end
    if (cmd.seg_set) begin
      seg_base_r[tidx] <= start_r;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      unique case (cmd.res_sel)
        RS_ZERO:  res_addr_r <= '0;
        RS_ADDR:  res_addr_r <= 10'(req_r.address);
        RS_START: res_addr_r <= start_w[9:0];
        RS_XLATE: res_addr_r <= xl_res;
      endcase
    end
    if (cmd.load_out) begin
      out_data_r.status         <= res_status_r;
      out_data_r.result_address <= res_addr_r;
    end
  end

  always_comb begin
    sts.bad_req      = !task_ok || (req_r.operation > OP_TRANSLATE);
    sts.is_alloc     = req_r.operation == OP_ALLOC;
    sts.is_free      = req_r.operation == OP_FREE;
    sts.is_reserve   = req_r.operation == OP_RESERVE;
    sts.is_release   = req_r.operation == OP_RELEASE;
    sts.is_translate = req_r.operation == OP_TRANSLATE;
    sts.size_bad     = (req_r.size == '0) || (17'(req_r.size) > 17'(HEAP_WORDS));
    sts.seg_valid    = seg_valid_r[tidx];
    sts.clear_last   = row_r == RAW'(ROWS - 1);
    sts.scan_found   = found_v;
    sts.scan_last    = row_r == RAW'(ROWS - 1);
    sts.slot_last    = slot_r == SW'(SLOTS_PER_TASK - 1);
    sts.mark_last    = row_r == hi_p[PW-1:ROW_SEL_W];
    sts.out_busy     = out_valid_r && !out_ready;
    if (sts.is_alloc) begin
      sts.slot_hit = !entry_valid_r[eidx];
    end else if (sts.is_free) begin
      sts.slot_hit = entry_valid_r[eidx] && (ent_start == HW'(req_r.address))
                     && (32'(ent_start) == 32'(req_r.address));
    end else begin
      sts.slot_hit = entry_valid_r[eidx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/bffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer that steps the datapath through each allocator operation.
// ----------------------------------------------------------------------------
module bffa_ctrl import bffa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bffa_sts_t sts,
  output bffa_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_DISPATCH = 11'b00000000100,
    S_SCAN_RD  = 11'b00000001000,
    S_SCAN_CHK = 11'b00000010000,
    S_GRANT    = 11'b00000100000,
    S_SLOT_RD  = 11'b00001000000,
    S_SLOT_CHK = 11'b00010000000,
    S_SEG_DROP = 11'b00100000000,
    S_MARK_RD  = 11'b01000000000,
    S_MARK_WR  = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    AM_FIN  = 2'd0,
    AM_SCAN = 2'd1,
    AM_NEXT = 2'd2
  } after_t;

  state_t state_r, state_nxt;
  after_t after_r, after_nxt;
  logic   fin_r, fin_nxt;

  assign in_ready = (state_r == S_IDLE) && !fin_r;

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    fin_nxt   = fin_r;
    cmd       = '0;

    // hand the finished result to the output register when it is free
    if (fin_r && !sts.out_busy) begin
      cmd.load_out = 1'b1;
      fin_nxt      = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          cmd.row_zero = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.row_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.res_set = 1'b1;
        cmd.res_sel = RS_ZERO;
        if (sts.bad_req) begin
          cmd.res_code = ST_NOT_FOUND;
          fin_nxt      = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.is_translate) begin
          cmd.res_code = ST_OK;
          cmd.res_sel  = RS_XLATE;
          fin_nxt      = 1'b1;
          state_nxt    = S_IDLE;
        end else if ((sts.is_alloc || sts.is_reserve) && sts.size_bad) begin
          cmd.res_code = ST_BAD_SIZE;
          fin_nxt      = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.is_alloc) begin
          cmd.res_set  = 1'b0;
          cmd.row_zero = 1'b1;
          state_nxt    = S_SCAN_RD;
        end else if (sts.is_reserve) begin
          cmd.res_set   = 1'b0;
          cmd.seg_clear = 1'b1;
          if (sts.seg_valid) begin
            cmd.mark_load = 1'b1;
            cmd.mark_src  = MS_SEG;
            cmd.mark_val  = 1'b0;
            after_nxt     = AM_SCAN;
            state_nxt     = S_MARK_RD;
          end else begin
            cmd.row_zero = 1'b1;
            state_nxt    = S_SCAN_RD;
          end
        end else begin
          cmd.res_set   = 1'b0;
          cmd.slot_zero = 1'b1;
          state_nxt     = S_SLOT_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_found) begin
          if (sts.is_alloc) begin
            cmd.slot_zero = 1'b1;
            state_nxt     = S_SLOT_RD;
          end else begin
            state_nxt = S_GRANT;
          end
        end else if (sts.scan_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NO_SPACE;
          cmd.res_sel  = RS_ZERO;
          fin_nxt      = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_GRANT: begin
        cmd.mark_load = 1'b1;
        cmd.mark_src  = MS_START;
        cmd.mark_val  = 1'b1;
        cmd.seg_set   = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_code  = ST_OK;
        cmd.res_sel   = RS_START;
        after_nxt     = AM_FIN;
        state_nxt     = S_MARK_RD;
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (sts.slot_hit) begin
          cmd.slot_take = 1'b1;
          cmd.mark_load = 1'b1;
          state_nxt     = S_MARK_RD;
          if (sts.is_alloc) begin
            cmd.mark_src = MS_START;
            cmd.mark_val = 1'b1;
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
            cmd.res_sel  = RS_START;
            after_nxt    = AM_FIN;
          end else if (sts.is_free) begin
            cmd.mark_src = MS_ENTRY;
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
            cmd.res_sel  = RS_ADDR;
            after_nxt    = AM_FIN;
          end else begin
            cmd.mark_src = MS_ENTRY;
            after_nxt    = AM_NEXT;
          end
        end else if (sts.slot_last) begin
          if (sts.is_release) begin
            state_nxt = S_SEG_DROP;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = sts.is_alloc ? ST_TABLE_FULL : ST_NOT_FOUND;
            cmd.res_sel  = RS_ZERO;
            fin_nxt      = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_SLOT_RD;
        end
      end
      S_SEG_DROP: begin
        cmd.seg_clear = 1'b1;
        cmd.res_set   = 1'b1;
        cmd.res_code  = ST_OK;
        cmd.res_sel   = RS_ZERO;
        if (sts.seg_valid) begin
          cmd.mark_load = 1'b1;
          cmd.mark_src  = MS_SEG;
          after_nxt     = AM_FIN;
          state_nxt     = S_MARK_RD;
        end else begin
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_nxt   = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        if (!sts.mark_last) begin
          cmd.row_inc = 1'b1;
          state_nxt   = S_MARK_RD;
        end else begin
          unique case (after_r)
            AM_SCAN: begin
              cmd.row_zero = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
            AM_NEXT: begin
              if (sts.slot_last) begin
                state_nxt = S_SEG_DROP;
              end else begin
                cmd.slot_inc = 1'b1;
                state_nxt    = S_SLOT_RD;
              end
            end
            default: begin
              fin_nxt   = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      after_r <= AM_FIN;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== rtl/bitmap_first_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_top
// Word-granular first-fit heap allocator with per-task slots and segments.
// ----------------------------------------------------------------------------
// One request is handled at a time, one result per request. After reset a
// clearing pass writes the occupancy bitmap, one 8-word row per cycle;
// requests are held off until it ends. Translate, bad requests and bad sizes
// are resolved in the dispatch state. The first-fit search reads one bitmap
// row and then checks it, row by row, until a fit is found or the last row
// has been checked. The slot table is walked one slot at a time, each slot
// read and then checked, and marking or releasing a block reads and then
// writes each bitmap row it touches (read-modify-write on one bitmap RAM).
// Release_task repeats that for every held block plus the segment. A finished
// result sits in an output register, so the next transaction is accepted
// while it waits to be taken.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_top import bffa_pkg::*; #(
  parameter int HEAP_WORDS     = HEAP_WORDS_DEF,
  parameter int SLOTS_PER_TASK = SLOTS_PER_TASK_DEF,
  parameter int TASKS          = TASKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bffa_cmd_t cmd;
  bffa_sts_t sts;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bffa_datapath #(
    .HEAP_WORDS     (HEAP_WORDS),
    .SLOTS_PER_TASK (SLOTS_PER_TASK),
    .TASKS          (TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
// A local heap predictor mirrors the occupancy bitmap, the slot tables and the
// task segments. Each accepted request is run through it, and the expected
// result is queued. The monitor compares every result taken against the oldest
// expected one. The sender and the receiver idle in random bursts. Once the
// receiver holds off for a long stretch, and once the sender waits until the
// block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top import bffa_pkg::*;;

  localparam int HEAP  = HEAP_WORDS_DEF;
  localparam int SLOTS = SLOTS_PER_TASK_DEF;
  localparam int NTASK = TASKS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  bitmap_first_fit_allocator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // heap predictor state, all clear at time zero
  bit        heap_used [HEAP];
  bit        slot_used [NTASK*SLOTS];
  int        slot_start [NTASK*SLOTS];
  int        slot_len [NTASK*SLOTS];
  bit        seg_held [NTASK];
  int        seg_base [NTASK];
  int        seg_len [NTASK];

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  int        idle_cycles;
  bit        send_idle_enable;
  bit        recv_idle_enable;
  bit        drain_hold;
  bit        long_hold_req;
  int        long_hold_cnt;
  int        send_gap;
  int        recv_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void heap_mark(int start, int len, bit v);
    for (int k = 0; k < len; k++)
      if (start + k < HEAP) heap_used[start + k] = v;
  endfunction

  function automatic bit heap_first_fit(int len, output int start);
    int run;
    int first;
    run = 0;
    first = 0;
    start = 0;
    for (int i = 0; i < HEAP; i++) begin
      if (heap_used[i]) begin
        run = 0;
      end else begin
        if (run == 0) first = i;
        run++;
        if (run == len) begin
          start = first;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void seg_drop(int t);
    if (seg_held[t]) heap_mark(seg_base[t], seg_len[t], 1'b0);
    seg_held[t] = 1'b0;
    seg_base[t] = 0;
    seg_len[t] = 0;
  endfunction

  function automatic out_item_t heap_predict(in_item_t req);
    out_item_t r;
    int t;
    int sz;
    int a;
    int b;
    int st;
    bit done;
    t = req.task_req;
    sz = req.size;
    a = req.address;
    b = t * SLOTS;
    st = 0;
    done = 1'b0;
    r.status = ST_NOT_FOUND;
    r.result_address = '0;
    if (t < NTASK) begin
      case (req.operation)
        OP_ALLOC: begin
          if (sz == 0 || sz > HEAP) begin
            r.status = ST_BAD_SIZE;
          end else if (!heap_first_fit(sz, st)) begin
            r.status = ST_NO_SPACE;
          end else begin
            r.status = ST_TABLE_FULL;
            for (int s = 0; s < SLOTS; s++) begin
              if (!done && !slot_used[b+s]) begin
                heap_mark(st, sz, 1'b1);
                slot_used[b+s] = 1'b1;
                slot_start[b+s] = st;
                slot_len[b+s] = sz;
                r.status = ST_OK;
                r.result_address = st[9:0];
                done = 1'b1;
              end
            end
          end
        end
        OP_FREE: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!done && slot_used[b+s] && slot_start[b+s] == a) begin
              heap_mark(a, slot_len[b+s], 1'b0);
              slot_used[b+s] = 1'b0;
              r.status = ST_OK;
              r.result_address = a[9:0];
              done = 1'b1;
            end
          end
        end
        OP_RESERVE: begin
          if (sz == 0 || sz > HEAP) begin
            r.status = ST_BAD_SIZE;
          end else begin
            seg_drop(t);
            if (!heap_first_fit(sz, st)) begin
              r.status = ST_NO_SPACE;
            end else begin
              heap_mark(st, sz, 1'b1);
              seg_held[t] = 1'b1;
              seg_base[t] = st;
              seg_len[t] = sz;
              r.status = ST_OK;
              r.result_address = st[9:0];
            end
          end
        end
        OP_RELEASE: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[b+s]) begin
              heap_mark(slot_start[b+s], slot_len[b+s], 1'b0);
              slot_used[b+s] = 1'b0;
            end
          end
          seg_drop(t);
          r.status = ST_OK;
        end
        OP_TRANSLATE: begin
          r.status = ST_OK;
          if (seg_held[t] && a < seg_len[t]) r.result_address = 10'(seg_base[t] + a);
          else r.result_address = a[9:0];
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t make_req(logic [2:0] op, int t, int sz, int a);
    in_item_t req;
    req.operation = op;
    req.task_req = t[1:0];
    req.size = sz[15:0];
    req.address = a[8:0];
    return req;
  endfunction

  // mostly small sizes so the heap cycles through full and empty
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 24);
    if (r < 80) return $urandom_range(25, 160);
    if (r < 88) return $urandom_range(161, HEAP);
    if (r < 92) return 0;
    if (r < 96) return HEAP;
    return $urandom_range(HEAP + 1, 65535);
  endfunction

  function automatic int pick_addr(int t);
    int s;
    s = t * SLOTS + $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 3) != 0 && slot_used[s]) return slot_start[s];
    return $urandom_range(0, HEAP - 1);
  endfunction

  // sender: one transaction per handshake, payload held until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (drain_hold || pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_idle_enable && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_results.push_back(heap_predict(in_data));
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
      long_hold_cnt <= 0;
    end else if (long_hold_req && long_hold_cnt == 0) begin
      long_hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (long_hold_cnt > 1) begin
      long_hold_cnt <= long_hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (long_hold_cnt == 1) begin
      long_hold_cnt <= -1;
      out_ready <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_enable && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d address %0d", out_data.status,
               out_data.result_address);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_data.status);
          error_count++;
        end
        if (out_data.result_address !== exp_r.result_address) begin
          $error("result_address: expected %0d, actual %0d", exp_r.result_address,
                 out_data.result_address);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int t;
    int r;
    rst_n = 1'b0;
    send_idle_enable = 1'b1;
    recv_idle_enable = 1'b1;
    drain_hold = 1'b0;
    long_hold_req = 1'b0;

    // directed: extremes, every operation, special cases
    pending_reqs.push_back(make_req(OP_TRANSLATE, 0, 0, 511));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 1, 65535, 0));
    pending_reqs.push_back(make_req(OP_RESERVE, 1, 513, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, HEAP, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 1, 1, 0));
    pending_reqs.push_back(make_req(OP_FREE, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_FREE, 0, 0, 0));
    pending_reqs.push_back(make_req(OP_RESERVE, 2, 100, 0));
    pending_reqs.push_back(make_req(OP_TRANSLATE, 2, 0, 99));
    pending_reqs.push_back(make_req(OP_TRANSLATE, 2, 0, 100));
    pending_reqs.push_back(make_req(OP_RESERVE, 2, 412, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 3, 101, 0));
    for (int i = 0; i < SLOTS + 1; i++) pending_reqs.push_back(make_req(OP_ALLOC, 3, 1, 0));
    pending_reqs.push_back(make_req(OP_RELEASE, 3, 65535, 511));
    pending_reqs.push_back(make_req(3'd7, 2, 5, 5));
    pending_reqs.push_back(make_req(3'd5, 1, 5, 5));
    pending_reqs.push_back(make_req(OP_RELEASE, 2, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // random phase; predictor state lags while items queue, so pick_addr
    // is only a hint for hitting live blocks
    for (int n = 0; n < 450; n++) begin
      t = $urandom_range(0, NTASK - 1);
      r = $urandom_range(0, 99);
      if (r < 40) pending_reqs.push_back(make_req(OP_ALLOC, t, pick_size(), $urandom));
      else if (r < 65) pending_reqs.push_back(make_req(OP_FREE, t, $urandom, pick_addr(t)));
      else if (r < 75) pending_reqs.push_back(make_req(OP_RESERVE, t, pick_size(), $urandom));
      else if (r < 82) pending_reqs.push_back(make_req(OP_RELEASE, t, $urandom, $urandom));
      else if (r < 97)
        pending_reqs.push_back(make_req(OP_TRANSLATE, t, $urandom, $urandom_range(0, 511)));
      else pending_reqs.push_back(make_req(3'($urandom_range(5, 7)), t, $urandom, $urandom));

      if (n == 120) begin
        // long receiver hold-off while sender keeps offering
        long_hold_req = 1'b1;
        wait (pending_reqs.size() == 0);
        wait (long_hold_cnt < 0);
        long_hold_req = 1'b0;
      end
      if (n == 250) begin
        // sender pauses until the block has drained
        wait (pending_reqs.size() == 0 && !in_valid);
        drain_hold = 1'b1;
        wait (expected_results.size() == 0);
        @(posedge clk);
        drain_hold = 1'b0;
      end
      if (n == 380) begin
        wait (pending_reqs.size() == 0);
        send_idle_enable = 1'b0;
        recv_idle_enable = 1'b0;
      end
    end

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== bitmap_first_fit_allocator_top.f =====
rtl/bffa_pkg.sv
rtl/bffa_ram.sv
rtl/bffa_datapath.sv
rtl/bffa_ctrl.sv
rtl/bitmap_first_fit_allocator_top.sv
bench/tb_top.sv
